// ===== sv/max_heap_priority_queue_assert.svh =====
// Assertion macros shared by the priority queue modules.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mhpq_pkg.sv =====
// Types and constants shared by the priority queue modules.
package mhpq_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned EntryW = 8;

  // Command codes of the input word
  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_REPLACE = 1'b1
  } command_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Input word
  typedef struct packed {
    logic                   command;
    logic signed [KeyW-1:0] value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [1:0]             status;
    logic signed [KeyW-1:0] top_value;
    logic [EntryW-1:0]      entry_total;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    set_status;
    status_e status;
    logic    start_ins;
    logic    start_rep;
    logic    up_read;
    logic    up_move;
    logic    dn_read;
    logic    dn_move;
    logic    place;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic parent_less;
    logic child_better;
  } dp_stat_t;

endpackage

// ===== sv/mhpq_dpath.sv =====
// Heap datapath: key store, entry count, hole position and moving key.
`include "max_heap_priority_queue_assert.svh"

module mhpq_dpath #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhpq_pkg::in_word_t  word_i,
  input  mhpq_pkg::dp_cmd_t   cmd_i,
  output mhpq_pkg::dp_stat_t  stat_o,
  output mhpq_pkg::out_word_t result_o
);

  localparam int unsigned SlotW  = $clog2(CAPACITY + 1);
  localparam int unsigned ChildW = SlotW + 1;
  localparam int unsigned AddrW  = $clog2(CAPACITY);

  // Key store, slot n lives at address n-1
  logic signed [mhpq_pkg::KeyW-1:0] mem [CAPACITY];

  logic [SlotW-1:0]                 count_q, count_d;
  logic [SlotW-1:0]                 pos_q, pos_d;
  logic signed [mhpq_pkg::KeyW-1:0] key_q, key_d;
  logic signed [mhpq_pkg::KeyW-1:0] top_q, top_d;
  mhpq_pkg::status_e                status_q, status_d;
  logic signed [mhpq_pkg::KeyW-1:0] rd_a_q, rd_b_q;

  logic [SlotW-1:0]                 parent_idx;
  logic [ChildW-1:0]                left_idx, right_idx, rd_a_sel, child_idx;
  logic                             left_ok, right_ok, take_left, take_right;
  logic signed [mhpq_pkg::KeyW-1:0] best_val, child_val, wr_data;
  logic                             wr_en, rd_en;
  logic [AddrW-1:0]                 wr_addr, rd_a_addr, rd_b_addr;

  // Tree neighbors of the hole
  assign parent_idx = pos_q >> 1;
  assign left_idx   = {pos_q, 1'b0};
  assign right_idx  = {pos_q, 1'b1};
  assign left_ok    = left_idx <= {1'b0, count_q};
  assign right_ok   = right_idx <= {1'b0, count_q};

  // Larger child that beats the moving key; left wins ties
  assign take_left  = left_ok && (rd_a_q > key_q);
  assign best_val   = take_left ? rd_a_q : key_q;
  assign take_right = right_ok && (rd_b_q > best_val);
  assign child_val  = take_right ? rd_b_q : rd_a_q;
  assign child_idx  = take_right ? right_idx : left_idx;

  // Read addresses: parent on port A going up, both children going down
  assign rd_a_sel  = cmd_i.up_read ? {1'b0, parent_idx} : left_idx;
  assign rd_a_addr = AddrW'(rd_a_sel - ChildW'(1));
  assign rd_b_addr = AddrW'(right_idx - ChildW'(1));
  assign rd_en     = cmd_i.up_read | cmd_i.dn_read;
  assign wr_addr   = AddrW'(pos_q - SlotW'(1));

  // Next state of count, hole and key; one store write per cycle
  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    key_d    = key_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_data  = key_q;
    if (cmd_i.set_status) begin
      status_d = cmd_i.status;
    end
    if (cmd_i.start_ins) begin
      count_d = count_q + SlotW'(1);
      pos_d   = count_q + SlotW'(1);
      key_d   = word_i.value;
    end
    if (cmd_i.start_rep) begin
      pos_d = SlotW'(1);
      key_d = word_i.value;
    end
    if (cmd_i.up_move) begin
      wr_en   = 1'b1;
      wr_data = rd_a_q;
      pos_d   = parent_idx;
    end
    if (cmd_i.dn_move) begin
      wr_en   = 1'b1;
      wr_data = child_val;
      pos_d   = SlotW'(child_idx);
    end
    if (cmd_i.place) begin
      wr_en   = 1'b1;
      wr_data = key_q;
    end
  end

  // Root mirror follows every write to slot one
  assign top_d = (wr_en && stat_o.at_root) ? wr_data : top_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      pos_q    <= '0;
      status_q <= mhpq_pkg::ST_OK;
    end else begin
      count_q  <= count_d;
      pos_q    <= pos_d;
      status_q <= status_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    top_q <= top_d;
  end

  // Key store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem[rd_a_addr];
      rd_b_q <= mem[rd_b_addr];
    end
  end

  // Status to controller
  assign stat_o.full         = count_q == SlotW'(CAPACITY);
  assign stat_o.empty        = count_q == '0;
  assign stat_o.at_root      = pos_q == SlotW'(1);
  assign stat_o.parent_less  = rd_a_q < key_q;
  assign stat_o.child_better = take_left | take_right;

  // Result word
  assign result_o.status      = status_q;
  assign result_o.top_value   = (count_q == '0) ? '0 : top_q;
  assign result_o.entry_total = mhpq_pkg::EntryW'(count_q);

  `MHPQ_ASSERT(a_count_cap, count_q <= SlotW'(CAPACITY), "entry count above capacity")
  `MHPQ_ASSERT(a_count_step, !$stable(count_q) |-> count_q == $past(count_q) + SlotW'(1), "entry count moved by other than one")
  `MHPQ_ASSERT(a_hole_range, (cmd_i.up_read || cmd_i.dn_read) |-> (pos_q != '0 && pos_q <= count_q), "hole outside live slots")

endmodule

// ===== sv/mhpq_ctrl.sv =====
// Heap controller: sequences insert sift-up and replace sift-down.
`include "max_heap_priority_queue_assert.svh"

module mhpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               command_i,
  input  mhpq_pkg::dp_stat_t stat_i,
  output mhpq_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UP_RD  = 6'b000010,
    S_UP_CMP = 6'b000100,
    S_DN_RD  = 6'b001000,
    S_DN_CMP = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.status  = mhpq_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.set_status = 1'b1;
          if (command_i == mhpq_pkg::CMD_INSERT) begin
            if (stat_i.full) begin
              cmd_o.status = mhpq_pkg::ST_FULL;
              state_d      = S_RESP;
            end else begin
              cmd_o.start_ins = 1'b1;
              state_d         = S_UP_RD;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.status = mhpq_pkg::ST_EMPTY;
              state_d      = S_RESP;
            end else begin
              cmd_o.start_rep = 1'b1;
              state_d         = S_DN_RD;
            end
          end
        end
      end
      // Hole at the root ends the climb, else fetch the parent
      S_UP_RD: begin
        if (stat_i.at_root) begin
          cmd_o.place = 1'b1;
          state_d     = S_RESP;
        end else begin
          cmd_o.up_read = 1'b1;
          state_d       = S_UP_CMP;
        end
      end
      // Smaller parent drops into the hole
      S_UP_CMP: begin
        if (stat_i.parent_less) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_RESP;
        end
      end
      S_DN_RD: begin
        cmd_o.dn_read = 1'b1;
        state_d       = S_DN_CMP;
      end
      // Larger child rises into the hole
      S_DN_CMP: begin
        if (stat_i.child_better) begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          cmd_o.place = 1'b1;
          state_d     = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = state_q == S_RESP;

  `MHPQ_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted word did not raise busy")
  `MHPQ_ASSERT_NEXT(a_done_idle, done_o, !busy_o && !done_o, "no return to idle after result")
  `MHPQ_ASSERT(a_one_write, $onehot0({cmd_o.up_move, cmd_o.dn_move, cmd_o.place}), "two store writes in one cycle")

endmodule

// ===== sv/max_heap_priority_queue.sv =====
// Top level of the binary max-heap priority queue.
//
// Binary max-heap of up to CAPACITY signed 32-bit keys. A command word is
// taken at a clock edge with start high and busy low; busy then stays high
// until the result word has been shown. Each command gives exactly one
// result word, held on result_o with done_o high for one cycle; the
// receiver cannot stall it. A rejected command (insert when full, replace
// when empty) goes from idle straight to the result state. An insert
// climbs by a parent read (UP_RD) and a compare that moves the smaller
// parent down into the hole (UP_CMP) per level, and ends with a place at
// the root or below a larger-or-equal parent; a replace sinks the root by
// a read of both children (DN_RD) and a compare-and-move (DN_CMP) per level.
// Each level needs one registered read and one compare-and-write because
// of the single key store. entry_total carries the low eight bits
// of the entry count; top_value reads zero while the heap is empty.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mhpq_pkg::in_word_t  word_i,
  output logic                done_o,
  output mhpq_pkg::out_word_t result_o
);

  mhpq_pkg::dp_cmd_t  dp_cmd;
  mhpq_pkg::dp_stat_t dp_stat;

  // Sequencer
  mhpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (word_i.command),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd),
    .busy_o    (busy),
    .done_o    (done_o)
  );

  // Store, count and compare logic
  mhpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .word_i   (word_i),
    .cmd_i    (dp_cmd),
    .stat_o   (dp_stat),
    .result_o (result_o)
  );

endmodule

// ===== dv/tb_max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// Testbench for the max-heap priority queue: random and directed command words, checked results.
module tb_max_heap_priority_queue;

  localparam int unsigned KeyW        = mhpq_pkg::KeyW;
  localparam int unsigned EntryW      = mhpq_pkg::EntryW;
  localparam int unsigned Depth       = 128;
  localparam int unsigned NumRandom   = 1700;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 40;
  // Words issued in this window go out back to back
  localparam int unsigned BurstLo     = 500;
  localparam int unsigned BurstHi     = 900;

  localparam logic signed [KeyW-1:0] KeyMax = 32'sh7FFF_FFFF;
  localparam logic signed [KeyW-1:0] KeyMin = 32'sh8000_0000;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start  = 1'b0;
  logic                busy;
  mhpq_pkg::in_word_t  word_i = '0;
  logic                done_o;
  mhpq_pkg::out_word_t result_o;

  mhpq_pkg::in_word_t     cmd_backlog[$];
  mhpq_pkg::out_word_t    results_due[$];
  logic signed [KeyW-1:0] shadow_heap [1:Depth];
  int unsigned            shadow_count   = 0;
  int unsigned            error_count    = 0;
  int unsigned            cycle_count    = 0;
  int unsigned            issued_count   = 0;
  int unsigned            accepted_count = 0;

  always #10 clk_i = ~clk_i;

  max_heap_priority_queue #(
    .CAPACITY(Depth)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .word_i  (word_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Apply one command to the shadow heap and return the result it must give
  function automatic mhpq_pkg::out_word_t heap_command(mhpq_pkg::in_word_t w);
    mhpq_pkg::out_word_t    r;
    int unsigned            pos;
    int unsigned            best;
    int unsigned            kid;
    logic signed [KeyW-1:0] tmp;
    bit                     sinking;
    r.status = mhpq_pkg::ST_OK;
    if (w.command == mhpq_pkg::CMD_INSERT) begin
      if (shadow_count >= Depth) begin
        r.status = mhpq_pkg::ST_FULL;
      end else begin
        // append, then climb past smaller parents
        shadow_count++;
        pos = shadow_count;
        shadow_heap[pos] = w.value;
        while (pos > 1 && shadow_heap[pos / 2] < shadow_heap[pos]) begin
          tmp                  = shadow_heap[pos / 2];
          shadow_heap[pos / 2] = shadow_heap[pos];
          shadow_heap[pos]     = tmp;
          pos                  = pos / 2;
        end
      end
    end else if (shadow_count == 0) begin
      r.status = mhpq_pkg::ST_EMPTY;
    end else begin
      // overwrite root, sink toward the strictly larger child (left wins ties)
      shadow_heap[1] = w.value;
      pos = 1;
      sinking = 1'b1;
      while (sinking) begin
        best = pos;
        kid  = 2 * pos;
        if (kid <= shadow_count && shadow_heap[kid] > shadow_heap[best]) best = kid;
        if (kid + 1 <= shadow_count && shadow_heap[kid + 1] > shadow_heap[best]) best = kid + 1;
        if (best == pos) begin
          sinking = 1'b0;
        end else begin
          tmp               = shadow_heap[pos];
          shadow_heap[pos]  = shadow_heap[best];
          shadow_heap[best] = tmp;
          pos               = best;
        end
      end
    end
    r.top_value   = (shadow_count > 0) ? shadow_heap[1] : '0;
    r.entry_total = shadow_count[EntryW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic queue_command(mhpq_pkg::command_e cmd, logic signed [KeyW-1:0] key);
    mhpq_pkg::in_word_t w;
    w.command = cmd;
    w.value   = key;
    cmd_backlog.push_back(w);
  endtask

  // Mostly wide random keys, some extremes, some narrow range for ties
  function automatic logic signed [KeyW-1:0] random_key();
    logic signed [KeyW-1:0] k;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       k = KeyMax;
          1:       k = KeyMin;
          2:       k = '0;
          default: k = -1;
        endcase
      end
      1, 2:    k = int'($urandom_range(16)) - 8;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Monitor: check result words, predict on each accepted command word
  always @(posedge clk_i) begin : monitor
    mhpq_pkg::out_word_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result word with none due: status %0d top %0d count %0d",
                                    result_o.status, result_o.top_value,
                                    result_o.entry_total));
        end else begin
          want = results_due.pop_front();
          if (result_o.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      result_o.status, want.status));
          if (result_o.top_value !== want.top_value)
            report_mismatch($sformatf("top_value got %0d want %0d",
                                      result_o.top_value, want.top_value));
          if (result_o.entry_total !== want.entry_total)
            report_mismatch($sformatf("entry_total got %0d want %0d",
                                      result_o.entry_total, want.entry_total));
        end
      end
      if (start && !busy) begin
        results_due.push_back(heap_command(word_i));
        accepted_count++;
      end
    end
  end

  // Driver: present the next command word once the current one is taken
  always @(negedge clk_i) begin : driver
    bit idle;
    if (rst_ni && accepted_count == issued_count) begin
      idle  = (issued_count < BurstLo || issued_count >= BurstHi) &&
              ($urandom_range(99) < 33);
      if (!idle && cmd_backlog.size() > 0) begin
        word_i <= cmd_backlog.pop_front();
        start  <= 1'b1;
        issued_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned        i;
    mhpq_pkg::command_e cmd;
    // directed: replace on empty, extreme keys, equal keys, deep sinks
    queue_command(mhpq_pkg::CMD_REPLACE, 32'sd7);
    queue_command(mhpq_pkg::CMD_INSERT, '0);
    queue_command(mhpq_pkg::CMD_INSERT, KeyMax);
    queue_command(mhpq_pkg::CMD_INSERT, KeyMin);
    queue_command(mhpq_pkg::CMD_INSERT, -1);
    queue_command(mhpq_pkg::CMD_INSERT, 32'sd5);
    queue_command(mhpq_pkg::CMD_INSERT, 32'sd5);
    queue_command(mhpq_pkg::CMD_INSERT, 32'sd5);
    queue_command(mhpq_pkg::CMD_INSERT, KeyMax);
    queue_command(mhpq_pkg::CMD_REPLACE, KeyMin);
    queue_command(mhpq_pkg::CMD_REPLACE, 32'sd5);
    queue_command(mhpq_pkg::CMD_REPLACE, KeyMax);
    queue_command(mhpq_pkg::CMD_REPLACE, '0);
    queue_command(mhpq_pkg::CMD_INSERT, 32'sh5555_5555);
    queue_command(mhpq_pkg::CMD_INSERT, 32'shAAAA_AAAA);
    queue_command(mhpq_pkg::CMD_INSERT, 32'sd1);
    queue_command(mhpq_pkg::CMD_REPLACE, -2);
    queue_command(mhpq_pkg::CMD_REPLACE, KeyMin);
    // random: insert-heavy until the heap fills, then mostly replaces
    // with some inserts that must bounce off the full heap
    for (i = 0; i < NumRandom; i++) begin
      if (i < 300) begin
        cmd = ($urandom_range(99) < 65) ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_REPLACE;
      end else begin
        cmd = ($urandom_range(99) < 25) ? mhpq_pkg::CMD_INSERT : mhpq_pkg::CMD_REPLACE;
      end
      queue_command(cmd, random_key());
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || accepted_count != issued_count ||
           results_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/mhpq_pkg.sv
sv/mhpq_dpath.sv
sv/mhpq_ctrl.sv
sv/max_heap_priority_queue.sv
dv/tb_max_heap_priority_queue.sv
